>>> src/pspt_pkg.sv
// Shared constants, types and state codes for the pc stride prefetch table.
// No dependencies; every other file imports this package.
package pspt_pkg;

	// table geometry and limits
	localparam int TABLE_ENTRIES = 16;
	localparam int MAX_CONF      = 3;
	localparam int MAX_DISTANCE  = 16;

	localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CONF_W      = $clog2(MAX_CONF + 1);
	localparam int CNT_W       = $clog2(MAX_DISTANCE + 1);
	localparam int TREE_LEVELS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TREE_SIZE   = 1 << TREE_LEVELS;
	localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// stream and register port widths
	localparam int PC_W     = 32;
	localparam int ADDR_W   = 64;
	localparam int TIME_W   = 64;
	localparam int STEP_W   = 5;
	localparam int IN_W     = 160;
	localparam int OUT_W    = 72;
	localparam int DIST_W   = 5;
	localparam int THR_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [DIST_W-1:0] DIST_RESET = 5'd4;
	localparam logic [THR_W-1:0]  THR_RESET  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISTANCE  = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [THR_W-1:0]  threshold;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] stride;
		logic [CNT_W-1:0]  run_len;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [PC_W-1:0]   pc;
		logic [ADDR_W-1:0] prev_addr;
		logic [ADDR_W-1:0] stride;
		logic [CONF_W-1:0] conf;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [IDX_W-1:0]  idx;
	} cand_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_LOOK,
		F_TREE,
		F_UPD
	} front_state_t;

endpackage

>>> src/pspt_queue.sv
// Small command FIFO between lookup front and prefetch back end.
// Depends on pspt_pkg for the command and status types.
module pspt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pspt_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output pspt_pkg::cmd_t     pop_cmd,
	output pspt_pkg::q_status_t status
);
	import pspt_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/pspt_front.sv
// Lookup front: accepts load accesses, searches and updates the stride table,
// picks the replacement victim and queues prefetch runs. Uses pspt_pkg.
module pspt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pspt_pkg::cfg_t          cfg,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// tdata: load_pc[31:0], load_address[95:32], access_time[159:96]
	input  logic [pspt_pkg::IN_W-1:0] s_tdata,
	input  pspt_pkg::q_status_t     q_status,
	output logic                    push,
	output pspt_pkg::cmd_t          push_cmd
);
	import pspt_pkg::*;

	front_state_t state_q, state_d;

	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t                   table_q [TABLE_ENTRIES];

	logic [PC_W-1:0]   pc_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] now_q;
	logic              hit_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LVL_W-1:0]  lvl_q;
	cand_t             cand_q [TREE_SIZE];
	cand_t             red    [TREE_SIZE/2];

	logic              accept;
	logic              any_hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              any_free;
	logic [IDX_W-1:0]  free_idx;
	logic              tree_done;

	entry_t            rd;
	logic [ADDR_W-1:0] obs_stride;
	logic              same;
	logic [ADDR_W-1:0] stride_n;
	logic [CONF_W-1:0] conf_n;
	logic [CNT_W-1:0]  run_len;
	logic              emit;
	logic              upd_fire;

	assign accept = s_tvalid && s_tready;

	// lowest-index valid tag match, lowest-index free slot
	always_comb begin
		any_hit  = 1'b0;
		hit_idx  = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && table_q[i].pc == pc_q) begin
				any_hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// one level of the oldest-stamp tree; ties keep the lower index
	always_comb begin
		for (int i = 0; i < TREE_SIZE / 2; i++) begin
			red[i] = (cand_q[2*i+1].stamp < cand_q[2*i].stamp) ? cand_q[2*i+1] : cand_q[2*i];
		end
	end

	assign tree_done = (lvl_q == LVL_W'(TREE_LEVELS - 1));

	// update datapath
	always_comb begin
		rd         = table_q[idx_q];
		obs_stride = addr_q - rd.prev_addr;
		same       = (rd.stride != '0) && (rd.stride == obs_stride);
		stride_n   = obs_stride;
		if (same) begin
			conf_n = (int'(rd.conf) < MAX_CONF) ? rd.conf + CONF_W'(1) : rd.conf;
		end else begin
			conf_n = '0;
		end
		if (int'(cfg.distance) > MAX_DISTANCE) begin
			run_len = CNT_W'(MAX_DISTANCE);
		end else begin
			run_len = CNT_W'(cfg.distance);
		end
		emit = hit_q && (stride_n != '0) && (int'(conf_n) >= int'(cfg.threshold))
			&& (run_len != '0);
	end

	assign upd_fire = (state_q == F_UPD) && !(emit && q_status.full);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (s_tvalid) state_d = F_LOOK;
			F_LOOK: begin
				if (any_hit || any_free || tree_done) begin
					state_d = F_UPD;
				end else begin
					state_d = F_TREE;
				end
			end
			F_TREE: if (tree_done) state_d = F_UPD;
			F_UPD:  if (upd_fire) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = (state_q == F_IDLE);
		push             = upd_fire && emit;
		push_cmd.addr    = addr_q;
		push_cmd.stride  = stride_n;
		push_cmd.run_len = run_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (upd_fire && !hit_q) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q   <= s_tdata[31:0];
			addr_q <= s_tdata[95:32];
			now_q  <= s_tdata[159:96];
			lvl_q  <= '0;
			for (int i = 0; i < TREE_SIZE; i++) begin
				if (i < TABLE_ENTRIES) begin
					cand_q[i].stamp <= table_q[i].stamp;
					cand_q[i].idx   <= IDX_W'(i);
				end else begin
					// padding never beats a real entry
					cand_q[i].stamp <= '1;
					cand_q[i].idx   <= '0;
				end
			end
		end else if (state_q == F_LOOK || state_q == F_TREE) begin
			for (int i = 0; i < TREE_SIZE / 2; i++) begin
				cand_q[i] <= red[i];
			end
			lvl_q <= lvl_q + 1'b1;
		end

		if (state_q == F_LOOK) begin
			hit_q <= any_hit;
			if (any_hit) begin
				idx_q <= hit_idx;
			end else if (any_free) begin
				idx_q <= free_idx;
			end else begin
				idx_q <= red[0].idx;
			end
		end else if (state_q == F_TREE) begin
			idx_q <= red[0].idx;
		end

		if (upd_fire) begin
			table_q[idx_q].stamp     <= now_q;
			table_q[idx_q].prev_addr <= addr_q;
			if (hit_q) begin
				table_q[idx_q].stride <= stride_n;
				table_q[idx_q].conf   <= conf_n;
			end else begin
				table_q[idx_q].pc     <= pc_q;
				table_q[idx_q].stride <= '0;
				table_q[idx_q].conf   <= '0;
			end
		end
	end

endmodule

>>> src/pspt_back.sv
// Prefetch back end: expands one queued run into address + n*stride items
// with a running adder, behind a registered output stage. Uses pspt_pkg.
module pspt_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pspt_pkg::q_status_t       q_status,
	input  pspt_pkg::cmd_t            pop_cmd,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// tdata: prefetch_address[63:0], step_number[68:64], zero pad[71:69]
	output logic [pspt_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);
	import pspt_pkg::*;

	logic              busy_q;
	logic [ADDR_W-1:0] acc_q;
	logic [ADDR_W-1:0] stride_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  dist_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STEP_W-1:0] out_step_q;
	logic              out_last_q;

	logic              adv;
	logic              run_last;
	logic [31:0]       n_ext;

	assign adv      = !out_valid_q || m_tready;
	assign pop      = !busy_q && !q_status.empty;
	assign run_last = (n_q == dist_q);
	assign n_ext    = 32'(n_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_step_q, out_addr_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && adv && run_last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q    <= pop_cmd.addr + pop_cmd.stride;
			stride_q <= pop_cmd.stride;
			dist_q   <= pop_cmd.run_len;
			n_q      <= CNT_W'(1);
		end else if (busy_q && adv) begin
			acc_q <= acc_q + stride_q;
			n_q   <= n_q + 1'b1;
		end
		if (busy_q && adv) begin
			out_addr_q <= acc_q;
			out_step_q <= n_ext[STEP_W-1:0];
			out_last_q <= run_last;
		end
	end

endmodule

>>> src/pc_stride_prefetch_table.sv
// Top level of the pc stride prefetch table: config registers, lookup front,
// command queue and prefetch back end. Depends on pspt_pkg and all submodules.
//
// Each load transfer (pc, address, time) is looked up by pc in a 16-entry fully
// associative table. A hit or a miss with a free slot goes through accept, tag
// compare and table write; a miss with a full table adds a registered
// oldest-stamp compare tree of log2(entries) levels before the table write.
// The front accepts the next load once the table write is done; a confident hit
// holds its table write while the queue is full. A confident hit
// hands a run to a 2-deep queue; the back end then sends one prefetch address
// per cycle while m_tready is high, from a running 64-bit adder, with tlast on
// the final one; runs overlap with lookups. Reset leaves every entry invalid.
// The user must send config writes only while the block is idle (not enforced).
module pc_stride_prefetch_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [pspt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pspt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata: load_pc[31:0], load_address[95:32], access_time[159:96]
	input  logic [pspt_pkg::IN_W-1:0]          s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata: prefetch_address[63:0], step_number[68:64], zero pad[71:69]
	output logic [pspt_pkg::OUT_W-1:0]         m_tdata,
	// tlast: last_of_run
	output logic                               m_tlast
);
	import pspt_pkg::*;

	cfg_t      cfg_q;
	q_status_t q_status;
	logic      q_push;
	logic      q_pop;
	cmd_t      push_cmd;
	cmd_t      pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance  <= DIST_RESET;
			cfg_q.threshold <= THR_RESET;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_DISTANCE:  cfg_q.distance  <= cfg_wdata[DIST_W-1:0];
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	pspt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_status (q_status),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	pspt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	pspt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_cmd  (pop_cmd),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// front must hold off when the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_status.full))
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("command popped from empty queue");

	// a run streams without gaps once its first item has been taken
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap inside a prefetch run");

endmodule
